[design/mmd_pkg.sv]
// Shared widths, latencies and types for the model matrix decomposition core.
package mmd_pkg;

  // Number format
  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int QuatBits = FracBits + 2;
  localparam int SizeBits = WordBits - 1;
  localparam int QBits    = FracBits + 1;      // quotient bits, one included
  localparam int SumBits  = FracBits + 3;      // sum or difference of two elements
  localparam int TrBits   = FracBits + 4;      // trace of three elements
  localparam int ArgBits  = FracBits + 5;      // root argument
  localparam int RadBits  = 2 * WordBits;
  localparam int NumBits  = WordBits + FracBits;

  localparam logic [QBits-1:0] OneFix = {1'b1, {FracBits{1'b0}}};

  // Pipeline latencies
  localparam int SqrtLat = WordBits;           // one root bit per stage
  localparam int DivLat  = FracBits + 3;       // input reg, QBits stages, output reg
  localparam int MagDly  = 2 + SqrtLat;
  localparam int SideDly = DivLat + 1 + SqrtLat + DivLat;
  localparam int OffDly  = 2 + SqrtLat + SideDly;
  localparam int NumDly  = SqrtLat;
  localparam int CodeDly = SqrtLat + DivLat;
  localparam int HalfDly = DivLat;

  // Which Shoemake branch was taken
  typedef enum logic [1:0] {
    BR_TRACE,
    BR_X,
    BR_Y,
    BR_Z
  } branch_e;

  typedef struct packed {
    logic [SizeBits-1:0] size_x;
    logic [SizeBits-1:0] size_y;
    logic [SizeBits-1:0] size_z;
    logic                degen;
  } side_t;

endpackage

[design/mmd_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module mmd_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [mmd_pkg::RadBits-1:0]   rad_i,
  output logic                          valid_o,
  output logic [mmd_pkg::WordBits-1:0]  root_o
);
  import mmd_pkg::*;

  logic [RadBits-1:0]  rem_q  [SqrtLat];
  logic [WordBits-1:0] root_q [SqrtLat];
  logic                vld_q  [SqrtLat];
  logic [RadBits-1:0]  rem_d  [SqrtLat];
  logic [WordBits-1:0] root_d [SqrtLat];

  // Try one root bit per stage against the running remainder
  always_comb begin
    logic [RadBits-1:0]  rem_in;
    logic [WordBits-1:0] root_in;
    logic [RadBits+1:0]  trial;
    int b;
    for (int s = 0; s < SqrtLat; s++) begin
      if (s == 0) begin
        rem_in  = rad_i;
        root_in = '0;
      end else begin
        rem_in  = rem_q[s-1];
        root_in = root_q[s-1];
      end
      b = WordBits - 1 - s;
      trial = ((RadBits+2)'(root_in) << (b + 1)) + ((RadBits+2)'(1) << (2 * b));
      if ({2'b00, rem_in} >= trial) begin
        rem_d[s]  = rem_in - trial[RadBits-1:0];
        root_d[s] = root_in | (WordBits'(1) << b);
      end else begin
        rem_d[s]  = rem_in;
        root_d[s] = root_in;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SqrtLat; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < SqrtLat; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // Advance remainder and partial root
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < SqrtLat; s++) begin
      rem_q[s]  <= rem_d[s];
      root_q[s] <= root_d[s];
    end
  end

  assign valid_o = vld_q[SqrtLat-1];
  assign root_o  = root_q[SqrtLat-1];

endmodule

[design/mmd_div.sv]
// Pipelined scaled divider: sign * min(num * 2^F / den, one), one quotient bit per stage.
module mmd_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic                                neg_i,
  input  logic [mmd_pkg::WordBits-1:0]        num_i,
  input  logic [mmd_pkg::WordBits-1:0]        den_i,
  output logic                                valid_o,
  output logic signed [mmd_pkg::QuatBits-1:0] quo_o
);
  import mmd_pkg::*;

  // Input stage
  logic                a_vld_q;
  logic                a_sat_q;
  logic                a_neg_q;
  logic [NumBits-1:0]  a_rem_q;
  logic [WordBits-1:0] a_den_q;

  // Quotient stages
  logic                vld_q [QBits];
  logic                sat_q [QBits];
  logic                neg_q [QBits];
  logic [NumBits-1:0]  rem_q [QBits];
  logic [QBits-1:0]    quo_q [QBits];
  logic [WordBits-1:0] den_q [QBits];
  logic [NumBits-1:0]  rem_d [QBits];
  logic [QBits-1:0]    quo_d [QBits];

  // Output stage
  logic                      o_vld_q;
  logic signed [QuatBits-1:0] o_quo_q;
  logic signed [QuatBits-1:0] o_quo_d;

  // Restoring division, one bit per stage
  always_comb begin
    logic [NumBits-1:0]  rem_in;
    logic [QBits-1:0]    quo_in;
    logic [WordBits-1:0] den_in;
    logic [NumBits:0]    shifted;
    int b;
    for (int s = 0; s < QBits; s++) begin
      if (s == 0) begin
        rem_in = a_rem_q;
        quo_in = '0;
        den_in = a_den_q;
      end else begin
        rem_in = rem_q[s-1];
        quo_in = quo_q[s-1];
        den_in = den_q[s-1];
      end
      b = QBits - 1 - s;
      shifted = (NumBits+1)'(den_in) << b;
      if ({1'b0, rem_in} >= shifted) begin
        rem_d[s] = rem_in - shifted[NumBits-1:0];
        quo_d[s] = quo_in | (QBits'(1) << b);
      end else begin
        rem_d[s] = rem_in;
        quo_d[s] = quo_in;
      end
    end
  end

  // Clamp to one and apply the sign
  always_comb begin
    logic [QBits-1:0] mag;
    if (sat_q[QBits-1] || quo_q[QBits-1] > OneFix) mag = OneFix;
    else mag = quo_q[QBits-1];
    if (neg_q[QBits-1]) o_quo_d = -signed'({1'b0, mag});
    else o_quo_d = signed'({1'b0, mag});
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
      for (int s = 0; s < QBits; s++) vld_q[s] <= 1'b0;
    end else begin
      a_vld_q  <= valid_i;
      vld_q[0] <= a_vld_q;
      for (int s = 1; s < QBits; s++) vld_q[s] <= vld_q[s-1];
      o_vld_q  <= vld_q[QBits-1];
    end
  end

  // Advance datapath; flag quotients of two or more, which the quotient bits cannot hold
  always_ff @(posedge clk_i) begin
    a_rem_q <= {num_i, {FracBits{1'b0}}};
    a_den_q <= den_i;
    a_neg_q <= neg_i;
    a_sat_q <= ({1'b0, num_i, {FracBits{1'b0}}} >= {den_i, {QBits{1'b0}}});
    for (int s = 0; s < QBits; s++) begin
      rem_q[s] <= rem_d[s];
      quo_q[s] <= quo_d[s];
    end
    den_q[0] <= a_den_q;
    sat_q[0] <= a_sat_q;
    neg_q[0] <= a_neg_q;
    for (int s = 1; s < QBits; s++) begin
      den_q[s] <= den_q[s-1];
      sat_q[s] <= sat_q[s-1];
      neg_q[s] <= neg_q[s-1];
    end
    o_quo_q <= o_quo_d;
  end

  assign valid_o = o_vld_q;
  assign quo_o   = o_quo_q;

endmodule

[design/model_matrix_decompose_core.sv]
// Top level: affine matrix to translation, scale and rotation quaternion.
//
// Usage: drive the twelve matrix fields and raise start_i for one cycle per
// transaction; a transaction is taken at every rising edge with start_i high.
// busy_o is always low: the pipeline takes a new matrix in every cycle.
// Each result is shown for one cycle with done_o high, in input order.
// Each matrix passes the input, square and sum registers, a square root
// pipeline, a divider pipeline, the branch register, a second square root
// pipeline, a second divider pipeline and the output register. Each root
// has WordBits stages of one root bit; each divider takes one quotient bit per stage.
// Throughput: one transaction per cycle.
// Reset clears all valid bits; no result is strobed until a transaction
// has passed through the whole pipeline. The receiver cannot stall, so
// the pipeline never holds.
module model_matrix_decompose_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [mmd_pkg::WordBits-1:0]  basis0_x_i,
  input  logic signed [mmd_pkg::WordBits-1:0]  basis0_y_i,
  input  logic signed [mmd_pkg::WordBits-1:0]  basis0_z_i,
  input  logic signed [mmd_pkg::WordBits-1:0]  basis1_x_i,
  input  logic signed [mmd_pkg::WordBits-1:0]  basis1_y_i,
  input  logic signed [mmd_pkg::WordBits-1:0]  basis1_z_i,
  input  logic signed [mmd_pkg::WordBits-1:0]  basis2_x_i,
  input  logic signed [mmd_pkg::WordBits-1:0]  basis2_y_i,
  input  logic signed [mmd_pkg::WordBits-1:0]  basis2_z_i,
  input  logic signed [mmd_pkg::WordBits-1:0]  offset_x_i,
  input  logic signed [mmd_pkg::WordBits-1:0]  offset_y_i,
  input  logic signed [mmd_pkg::WordBits-1:0]  offset_z_i,
  output logic                                 done_o,
  output logic signed [mmd_pkg::WordBits-1:0]  move_x_o,
  output logic signed [mmd_pkg::WordBits-1:0]  move_y_o,
  output logic signed [mmd_pkg::WordBits-1:0]  move_z_o,
  output logic signed [mmd_pkg::QuatBits-1:0] quat_w_o,
  output logic signed [mmd_pkg::QuatBits-1:0] quat_x_o,
  output logic signed [mmd_pkg::QuatBits-1:0] quat_y_o,
  output logic signed [mmd_pkg::QuatBits-1:0] quat_z_o,
  output logic [mmd_pkg::SizeBits-1:0]        size_x_o,
  output logic [mmd_pkg::SizeBits-1:0]        size_y_o,
  output logic [mmd_pkg::SizeBits-1:0]        size_z_o,
  output logic                                 degenerate_o
);
  import mmd_pkg::*;

  logic accept;
  logic [WordBits-1:0] in_w  [9];
  logic [WordBits-1:0] off_w [3];

  // Stage 0: magnitudes and signs
  logic                in_vld_q;
  logic [WordBits-1:0] mag_q [9];
  logic                neg_q [9];
  logic [WordBits-1:0] off_q [3];

  // Stages 1 and 2: squares and sums
  logic               sq_vld_q;
  logic [RadBits-1:0] sq_q [9];
  logic               sum_vld_q;
  logic [RadBits-1:0] sum_q [3];

  // Column lengths
  logic                len_vld [3];
  logic [WordBits-1:0] len_w   [3];
  logic                len_ok;
  side_t               side_w;

  // Delay lines
  logic [WordBits-1:0] mag_dly_q [MagDly][9];
  logic                neg_dly_q [MagDly][9];
  logic [WordBits-1:0] off_dly_q [OffDly][3];
  side_t               side_dly_q [SideDly];

  // Normalized matrix, m_w[column][row]
  logic                       m_vld [3][3];
  logic signed [QuatBits-1:0] m_w   [3][3];
  logic                       m_ok;

  // Branch stage
  logic                      c_vld_q;
  branch_e                   code_q, code_d;
  logic signed [ArgBits-1:0] arg_q, arg_d;
  logic signed [SumBits-1:0] cnum_q [4];
  logic signed [SumBits-1:0] cnum_d [4];
  logic signed [TrBits-1:0]  trace;

  // Second root and the quaternion divides
  logic [RadBits-1:0]        rad2;
  logic                      root_vld;
  logic [WordBits-1:0]       root_w;
  logic [WordBits-1:0]       root_fix;
  logic [WordBits-1:0]       den2;
  logic signed [SumBits-1:0] num_dly_q [NumDly][4];
  branch_e                   code_dly_q [CodeDly];
  logic [QBits-1:0]          half_dly_q [HalfDly];
  logic                      q_vld [4];
  logic signed [QuatBits-1:0] q_w  [4];
  logic                      q_ok;

  // Output registers
  logic                       done_q;
  logic signed [QuatBits-1:0] qw_q, qx_q, qy_q, qz_q;
  logic signed [QuatBits-1:0] qw_d, qx_d, qy_d, qz_d;
  logic [WordBits-1:0]        mv_q [3];
  side_t                      so_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign in_w[0] = basis0_x_i;
  assign in_w[1] = basis0_y_i;
  assign in_w[2] = basis0_z_i;
  assign in_w[3] = basis1_x_i;
  assign in_w[4] = basis1_y_i;
  assign in_w[5] = basis1_z_i;
  assign in_w[6] = basis2_x_i;
  assign in_w[7] = basis2_y_i;
  assign in_w[8] = basis2_z_i;
  assign off_w[0] = offset_x_i;
  assign off_w[1] = offset_y_i;
  assign off_w[2] = offset_z_i;

  // Valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      sq_vld_q  <= 1'b0;
      sum_vld_q <= 1'b0;
      c_vld_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      in_vld_q  <= accept;
      sq_vld_q  <= in_vld_q;
      sum_vld_q <= sq_vld_q;
      c_vld_q   <= m_ok;
      done_q    <= q_ok;
    end
  end

  // Split into magnitude and sign, square, sum per column
  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 9; n++) begin
      neg_q[n] <= in_w[n][WordBits-1];
      mag_q[n] <= in_w[n][WordBits-1] ? (~in_w[n] + WordBits'(1)) : in_w[n];
      sq_q[n]  <= RadBits'(mag_q[n]) * RadBits'(mag_q[n]);
    end
    for (int c = 0; c < 3; c++) begin
      off_q[c] <= off_w[c];
      sum_q[c] <= sq_q[3*c] + sq_q[3*c+1] + sq_q[3*c+2];
    end
  end

  // Column lengths
  for (genvar c = 0; c < 3; c++) begin : g_len
    mmd_sqrt u_len (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sum_vld_q),
      .rad_i   (sum_q[c]),
      .valid_o (len_vld[c]),
      .root_o  (len_w[c])
    );
  end

  assign len_ok = len_vld[0] & len_vld[1] & len_vld[2];

  // Saturate the sizes and flag a zero length
  always_comb begin
    side_w.size_x = len_w[0][WordBits-1] ? '1 : len_w[0][SizeBits-1:0];
    side_w.size_y = len_w[1][WordBits-1] ? '1 : len_w[1][SizeBits-1:0];
    side_w.size_z = len_w[2][WordBits-1] ? '1 : len_w[2][SizeBits-1:0];
    side_w.degen  = (len_w[0] == '0) | (len_w[1] == '0) | (len_w[2] == '0);
  end

  // Delay lines for the side data
  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 9; n++) begin
      mag_dly_q[0][n] <= mag_q[n];
      neg_dly_q[0][n] <= neg_q[n];
    end
    for (int k = 1; k < MagDly; k++) begin
      for (int n = 0; n < 9; n++) begin
        mag_dly_q[k][n] <= mag_dly_q[k-1][n];
        neg_dly_q[k][n] <= neg_dly_q[k-1][n];
      end
    end
    for (int c = 0; c < 3; c++) off_dly_q[0][c] <= off_q[c];
    for (int k = 1; k < OffDly; k++) begin
      for (int c = 0; c < 3; c++) off_dly_q[k][c] <= off_dly_q[k-1][c];
    end
    side_dly_q[0] <= side_w;
    for (int k = 1; k < SideDly; k++) side_dly_q[k] <= side_dly_q[k-1];
  end

  // Normalize each element by its column length
  for (genvar c = 0; c < 3; c++) begin : g_ncol
    for (genvar r = 0; r < 3; r++) begin : g_nrow
      mmd_div u_norm (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (len_ok),
        .neg_i   (neg_dly_q[MagDly-1][3*c+r]),
        .num_i   (mag_dly_q[MagDly-1][3*c+r]),
        .den_i   (len_w[c]),
        .valid_o (m_vld[c][r]),
        .quo_o   (m_w[c][r])
      );
    end
  end

  always_comb begin
    m_ok = 1'b1;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) m_ok = m_ok & m_vld[c][r];
    end
  end

  // Pick the branch, the root argument and the three numerators
  always_comb begin
    trace = TrBits'(m_w[0][0]) + TrBits'(m_w[1][1]) + TrBits'(m_w[2][2]);
    if (trace > 0) code_d = BR_TRACE;
    else if (m_w[1][1] > m_w[0][0]) code_d = (m_w[2][2] > m_w[1][1]) ? BR_Z : BR_Y;
    else code_d = (m_w[2][2] > m_w[0][0]) ? BR_Z : BR_X;
    for (int s = 0; s < 4; s++) cnum_d[s] = '0;
    case (code_d)
      BR_TRACE: begin
        arg_d     = ArgBits'(trace) + ArgBits'(OneFix);
        cnum_d[1] = SumBits'(m_w[1][2]) - SumBits'(m_w[2][1]);
        cnum_d[2] = SumBits'(m_w[2][0]) - SumBits'(m_w[0][2]);
        cnum_d[3] = SumBits'(m_w[0][1]) - SumBits'(m_w[1][0]);
      end
      BR_X: begin
        arg_d     = ArgBits'(m_w[0][0]) - ArgBits'(m_w[1][1]) - ArgBits'(m_w[2][2])
                    + ArgBits'(OneFix);
        cnum_d[0] = SumBits'(m_w[1][2]) - SumBits'(m_w[2][1]);
        cnum_d[2] = SumBits'(m_w[0][1]) + SumBits'(m_w[1][0]);
        cnum_d[3] = SumBits'(m_w[0][2]) + SumBits'(m_w[2][0]);
      end
      BR_Y: begin
        arg_d     = ArgBits'(m_w[1][1]) - ArgBits'(m_w[2][2]) - ArgBits'(m_w[0][0])
                    + ArgBits'(OneFix);
        cnum_d[0] = SumBits'(m_w[2][0]) - SumBits'(m_w[0][2]);
        cnum_d[3] = SumBits'(m_w[1][2]) + SumBits'(m_w[2][1]);
        cnum_d[1] = SumBits'(m_w[1][0]) + SumBits'(m_w[0][1]);
      end
      default: begin
        arg_d     = ArgBits'(m_w[2][2]) - ArgBits'(m_w[0][0]) - ArgBits'(m_w[1][1])
                    + ArgBits'(OneFix);
        cnum_d[0] = SumBits'(m_w[0][1]) - SumBits'(m_w[1][0]);
        cnum_d[1] = SumBits'(m_w[2][0]) + SumBits'(m_w[0][2]);
        cnum_d[2] = SumBits'(m_w[2][1]) + SumBits'(m_w[1][2]);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    arg_q  <= arg_d;
    for (int s = 0; s < 4; s++) cnum_q[s] <= cnum_d[s];
  end

  // Root of the argument scaled by one; a non-positive argument gives zero
  assign rad2 = (arg_q > 0) ? (RadBits'(arg_q) << FracBits) : '0;

  mmd_sqrt u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_vld_q),
    .rad_i   (rad2),
    .valid_o (root_vld),
    .root_o  (root_w)
  );

  assign root_fix = (root_w == '0) ? WordBits'(1) : root_w;
  assign den2     = root_fix << 1;

  // Hold numerators, branch and half root until their partners arrive
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < 4; s++) num_dly_q[0][s] <= cnum_q[s];
    for (int k = 1; k < NumDly; k++) begin
      for (int s = 0; s < 4; s++) num_dly_q[k][s] <= num_dly_q[k-1][s];
    end
    code_dly_q[0] <= code_q;
    for (int k = 1; k < CodeDly; k++) code_dly_q[k] <= code_dly_q[k-1];
    half_dly_q[0] <= root_fix[QBits:1];
    for (int k = 1; k < HalfDly; k++) half_dly_q[k] <= half_dly_q[k-1];
  end

  // Quaternion components other than the root one
  for (genvar s = 0; s < 4; s++) begin : g_quat
    logic signed [SumBits-1:0] nv;
    logic [SumBits-1:0]        nm;
    assign nv = num_dly_q[NumDly-1][s];
    assign nm = nv[SumBits-1] ? SumBits'(-nv) : nv;
    mmd_div u_quat (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (root_vld),
      .neg_i   (nv[SumBits-1]),
      .num_i   ({{(WordBits-SumBits){1'b0}}, nm}),
      .den_i   (den2),
      .valid_o (q_vld[s]),
      .quo_o   (q_w[s])
    );
  end

  assign q_ok = q_vld[0] & q_vld[1] & q_vld[2] & q_vld[3];

  // Place the half root, then force identity on a degenerate matrix
  always_comb begin
    logic [QBits-1:0]           hm;
    logic signed [QuatBits-1:0] hv;
    hm = (half_dly_q[HalfDly-1] > OneFix) ? OneFix : half_dly_q[HalfDly-1];
    hv = signed'({1'b0, hm});
    qw_d = q_w[0];
    qx_d = q_w[1];
    qy_d = q_w[2];
    qz_d = q_w[3];
    case (code_dly_q[CodeDly-1])
      BR_TRACE: qw_d = hv;
      BR_X:     qx_d = hv;
      BR_Y:     qy_d = hv;
      default:  qz_d = hv;
    endcase
    if (side_dly_q[SideDly-1].degen) begin
      qw_d = signed'({1'b0, OneFix});
      qx_d = '0;
      qy_d = '0;
      qz_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    qw_q <= qw_d;
    qx_q <= qx_d;
    qy_q <= qy_d;
    qz_q <= qz_d;
    for (int c = 0; c < 3; c++) mv_q[c] <= off_dly_q[OffDly-1][c];
    so_q <= side_dly_q[SideDly-1];
  end

  assign done_o       = done_q;
  assign move_x_o     = mv_q[0];
  assign move_y_o     = mv_q[1];
  assign move_z_o     = mv_q[2];
  assign quat_w_o     = qw_q;
  assign quat_x_o     = qx_q;
  assign quat_y_o     = qy_q;
  assign quat_z_o     = qz_q;
  assign size_x_o     = so_q.size_x;
  assign size_y_o     = so_q.size_y;
  assign size_z_o     = so_q.size_z;
  assign degenerate_o = so_q.degen;

endmodule

[sim/tb_model_matrix_decompose_core.sv]
// Self-checking testbench for the model matrix decomposition core.
module tb_model_matrix_decompose_core;
  import mmd_pkg::*;

  localparam int NumRandom  = 1650;
  localparam int Latency    = 107;
  localparam int CycleLimit = 200000;

  typedef logic signed [WordBits-1:0] word_t;

  typedef struct {
    word_t b[9];
    word_t off[3];
  } matrix_t;

  typedef struct {
    word_t               move[3];
    logic [QuatBits-1:0] quat[4];
    logic [SizeBits-1:0] size[3];
    logic                degen;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  word_t bin [9] = '{default: '0};
  word_t oin [3] = '{default: '0};
  logic done_o;
  word_t move_x_o, move_y_o, move_z_o;
  logic signed [QuatBits-1:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;
  logic [SizeBits-1:0] size_x_o, size_y_o, size_z_o;
  logic degenerate_o;

  matrix_t pending_q[$];
  pose_t   pose_q[$];
  int      errors = 0;
  int      cycles = 0;
  int      n_sent = 0;
  int      n_got = 0;
  int      n_degen = 0;
  bit      drain_req = 1'b0;
  bit      all_fed = 1'b0;
  int      burst_left = 0;
  int      gap_left = 0;

  model_matrix_decompose_core u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .basis0_x_i(bin[0]), .basis0_y_i(bin[1]), .basis0_z_i(bin[2]),
    .basis1_x_i(bin[3]), .basis1_y_i(bin[4]), .basis1_z_i(bin[5]),
    .basis2_x_i(bin[6]), .basis2_y_i(bin[7]), .basis2_z_i(bin[8]),
    .offset_x_i(oin[0]), .offset_y_i(oin[1]), .offset_z_i(oin[2]),
    .done_o, .move_x_o, .move_y_o, .move_z_o,
    .quat_w_o, .quat_x_o, .quat_y_o, .quat_z_o,
    .size_x_o, .size_y_o, .size_z_o, .degenerate_o
  );

  always #1 clk_i = ~clk_i;

  // Floor square root of a 128-bit value
  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= v) r = c;
    end
    return r;
  endfunction

  // Signed (num * 2^F) / den, truncated toward zero
  function automatic longint sdiv(longint num, logic [63:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (num < 0) ? 128'(-num) : 128'(num);
    q = (mag << FracBits) / 128'(den);
    return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [63:0] root_fix(longint arg);
    logic [63:0] r;
    r = isqrt((arg > 0) ? (128'(arg) << FracBits) : 128'd0);
    return (r == 0) ? 64'd1 : r;
  endfunction

  // Work out translation, scale and rotation of one matrix
  function automatic pose_t decompose(matrix_t mx);
    pose_t p;
    longint m[3][3];
    longint qv[4];
    longint one;
    longint tr;
    logic [63:0] mag[3];
    logic [127:0] sum;
    logic [63:0] len;
    logic [63:0] rt;
    int i, j, k;
    one = longint'(1) << FracBits;
    p.degen = 1'b0;
    for (int c = 0; c < 3; c++) begin
      sum = '0;
      for (int r = 0; r < 3; r++) begin
        mag[r] = (mx.b[c*3+r] < 0) ? 64'(-longint'(mx.b[c*3+r])) : 64'(mx.b[c*3+r]);
        sum += 128'(mag[r]) * 128'(mag[r]);
      end
      len = isqrt(sum);
      p.size[c] = (len > 64'h7FFF_FFFF) ? {SizeBits{1'b1}} : len[SizeBits-1:0];
      for (int r = 0; r < 3; r++)
        m[c][r] = (len == 0) ? 0 : sdiv(longint'(mx.b[c*3+r]), len);
      if (len == 0) p.degen = 1'b1;
    end
    for (int r = 0; r < 3; r++) p.move[r] = mx.off[r];
    qv = '{one, 0, 0, 0};
    if (!p.degen) begin
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
        rt = root_fix(tr + one);
        qv[0] = longint'(rt >> 1);
        qv[1] = sdiv(m[1][2] - m[2][1], rt * 2);
        qv[2] = sdiv(m[2][0] - m[0][2], rt * 2);
        qv[3] = sdiv(m[0][1] - m[1][0], rt * 2);
      end else begin
        i = 0;
        if (m[1][1] > m[0][0]) i = 1;
        if (m[2][2] > m[i][i]) i = 2;
        j = (i + 1) % 3;
        k = (j + 1) % 3;
        rt = root_fix(m[i][i] - m[j][j] - m[k][k] + one);
        qv[1+i] = longint'(rt >> 1);
        qv[1+j] = sdiv(m[i][j] + m[j][i], rt * 2);
        qv[1+k] = sdiv(m[i][k] + m[k][i], rt * 2);
        qv[0] = sdiv(m[j][k] - m[k][j], rt * 2);
      end
    end
    for (int r = 0; r < 4; r++) begin
      if (qv[r] > one) qv[r] = one;
      if (qv[r] < -one) qv[r] = -one;
      p.quat[r] = qv[r][QuatBits-1:0];
    end
    return p;
  endfunction

  // Driver: bursts of transactions with random gaps, change on falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        // the transaction presented last cycle was taken at the rising edge
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (drain_req && pending_q.size() > 0 && pose_q.size() > 0) begin
        start_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        matrix_t mx;
        mx = pending_q.pop_front();
        if (mx.b[0] === 'x) ;
        bin <= mx.b;
        oin <= mx.off;
        start_i <= 1'b1;
        pose_q.push_back(decompose(mx));
        n_sent <= n_sent + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start_i <= 1'b0;
        all_fed <= 1'b1;
      end
    end
  end

  // Monitor: sample at the rising edge and compare with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (done_o) begin
        if (pose_q.size() == 0) begin
          $error("result strobed with no transaction outstanding");
          errors++;
        end else begin
          pose_t e;
          e = pose_q.pop_front();
          n_got <= n_got + 1;
          if (e.degen) n_degen <= n_degen + 1;
          if (move_x_o !== e.move[0]) begin
            $error("move_x exp %h got %h", e.move[0], move_x_o); errors++;
          end
          if (move_y_o !== e.move[1]) begin
            $error("move_y exp %h got %h", e.move[1], move_y_o); errors++;
          end
          if (move_z_o !== e.move[2]) begin
            $error("move_z exp %h got %h", e.move[2], move_z_o); errors++;
          end
          if (quat_w_o !== e.quat[0]) begin
            $error("quat_w exp %h got %h", e.quat[0], quat_w_o); errors++;
          end
          if (quat_x_o !== e.quat[1]) begin
            $error("quat_x exp %h got %h", e.quat[1], quat_x_o); errors++;
          end
          if (quat_y_o !== e.quat[2]) begin
            $error("quat_y exp %h got %h", e.quat[2], quat_y_o); errors++;
          end
          if (quat_z_o !== e.quat[3]) begin
            $error("quat_z exp %h got %h", e.quat[3], quat_z_o); errors++;
          end
          if (size_x_o !== e.size[0]) begin
            $error("size_x exp %h got %h", e.size[0], size_x_o); errors++;
          end
          if (size_y_o !== e.size[1]) begin
            $error("size_y exp %h got %h", e.size[1], size_y_o); errors++;
          end
          if (size_z_o !== e.size[2]) begin
            $error("size_z exp %h got %h", e.size[2], size_z_o); errors++;
          end
          if (degenerate_o !== e.degen) begin
            $error("degenerate exp %b got %b", e.degen, degenerate_o); errors++;
          end
        end
      end
    end
  end

  function automatic word_t rand_word(int kind);
    case (kind)
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 131072)) - word_t'(65536);
      2: return 0;
      3: return word_t'(32'h8000_0000);
      default: return word_t'(32'h7FFF_FFFF);
    endcase
  endfunction

  // Unit-ish rotation with random scale: signed permutation times a scale
  function automatic matrix_t rand_rotation();
    matrix_t mx;
    int perm[3];
    int s;
    int t;
    perm = '{0, 1, 2};
    for (int a = 2; a > 0; a--) begin
      s = $urandom_range(0, a);
      t = perm[a]; perm[a] = perm[s]; perm[s] = t;
    end
    for (int c = 0; c < 9; c++) mx.b[c] = word_t'($urandom_range(0, 3000)) - 1500;
    for (int c = 0; c < 3; c++) begin
      s = $urandom_range(1, 800) * 256;
      mx.b[c*3+perm[c]] = ($urandom_range(0, 1) ? s : -s) * ($urandom_range(1, 4));
    end
    for (int r = 0; r < 3; r++) mx.off[r] = word_t'($urandom);
    return mx;
  endfunction

  function automatic matrix_t diag(word_t a, word_t b, word_t c);
    matrix_t mx;
    foreach (mx.b[n]) mx.b[n] = 0;
    mx.b[0] = a; mx.b[4] = b; mx.b[8] = c;
    foreach (mx.off[n]) mx.off[n] = 0;
    return mx;
  endfunction

  initial begin
    matrix_t mx;
    int kind;
    // Directed: identity, each diagonal branch, zero basis, extremes
    pending_q.push_back(diag(65536, 65536, 65536));
    pending_q.push_back(diag(65536, -65536, -65536));
    pending_q.push_back(diag(-65536, 65536, -65536));
    pending_q.push_back(diag(-65536, -65536, 65536));
    pending_q.push_back(diag(-65536, -65536, -65536));
    pending_q.push_back(diag(0, 65536, 65536));
    pending_q.push_back(diag(65536, 0, 65536));
    pending_q.push_back(diag(65536, 65536, 0));
    pending_q.push_back(diag(0, 0, 0));
    mx = diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    mx.off = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    pending_q.push_back(mx);
    foreach (mx.b[n]) mx.b[n] = 32'h8000_0000;
    pending_q.push_back(mx);
    foreach (mx.b[n]) mx.b[n] = 32'h7FFF_FFFF;
    pending_q.push_back(mx);
    foreach (mx.b[n]) mx.b[n] = 32'hFFFF_FFFF;
    pending_q.push_back(mx);
    // Non-rotation: sheared and mirrored columns, saturating quaternion
    mx = diag(65536, 65536, 65536);
    mx.b[1] = 65536; mx.b[3] = -65536;
    pending_q.push_back(mx);
    mx = diag(65536, 65536, -65536);
    mx.b[5] = 65536; mx.b[7] = 65536;
    pending_q.push_back(mx);
    mx = diag(0, 0, 0);
    mx.b[1] = 65536; mx.b[5] = 65536; mx.b[6] = 65536;
    pending_q.push_back(mx);
    mx = diag(1, 1, 1);
    pending_q.push_back(mx);
    // Random: mostly rotation-like matrices, the rest raw words
    for (int n = 0; n < NumRandom; n++) begin
      if ($urandom_range(0, 9) < 6) begin
        mx = rand_rotation();
      end else begin
        kind = $urandom_range(0, 5);
        for (int c = 0; c < 9; c++)
          mx.b[c] = rand_word(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : kind % 2);
        for (int r = 0; r < 3; r++) mx.off[r] = rand_word($urandom_range(0, 4));
        if ($urandom_range(0, 30) == 0)
          for (int r = 0; r < 3; r++) mx.b[$urandom_range(0, 2)*3+r] = 0;
      end
      pending_q.push_back(mx);
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Hold off the sender once mid-run until the pipeline drains
    wait (n_sent >= 800);
    drain_req = 1'b1;
    wait (pose_q.size() == 0);
    drain_req = 1'b0;
    wait (all_fed && pose_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    $display("Checked %0d matrices (%0d degenerate) including directed edge cases.",
             n_got, n_degen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
